// ----- hw/rtl/rlbh_pkg.sv -----
// ----------------------------------------------------------------------------
// rlbh_pkg
// Shared types, constants and helpers of the RLE / bit-packing hybrid decoder.
// ----------------------------------------------------------------------------
package rlbh_pkg;

  // Default and upper bound of the value width the decoder handles.
  localparam int RLBH_MAX_WIDTH = 32;
  // Default depth of the command queue between front and back.
  localparam int RLBH_CMD_DEPTH = 2;
  // Group payload carried in a command: eight values of up to 32 bits.
  localparam int GRP_BITS = 256;
  // A varint header longer than this many bytes is invalid.
  localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;
  // Bits of a varint byte that carry payload, and its continuation bit.
  localparam logic [7:0] VARINT_PAYLOAD = 8'h7F;
  localparam int VARINT_CONT_BIT = 7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [33:0] run_len;
    logic        error;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VALUE,
    PH_GROUP
  } phase_t;

  typedef enum logic [1:0] {
    CK_SINGLE,  // one (value, count) result
    CK_GROUP,   // eight packed values of count 1
    CK_ERROR    // one error result
  } cmd_kind_t;

  // One decoded event, handed from the front to the back.
  typedef struct packed {
    cmd_kind_t             kind;
    logic                  tail_err;  // append an error / flag the eighth value
    logic [5:0]            width;
    logic [31:0]           value;
    logic [33:0]           count;
    logic [GRP_BITS-1:0]   grp;
  } rlbh_cmd_t;

  typedef struct packed {
    logic idle;
    logic failed;
  } front_stat_t;

  function automatic logic [31:0] width_mask(input logic [5:0] w);
    logic [32:0] ones;
    ones = (33'd1 << w) - 33'd1;
    if (w >= 6'd32) begin
      width_mask = '1;
    end else begin
      width_mask = ones[31:0];
    end
  endfunction

endpackage

// ----- hw/rtl/rlbh_front.sv -----
// ----------------------------------------------------------------------------
// rlbh_front
// Byte parser: varint headers, repeat values and packed groups into commands.
// ----------------------------------------------------------------------------
module rlbh_front
  import rlbh_pkg::*;
#(
  parameter int MAX_WIDTH = RLBH_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  in_item_t    item,
  input  logic [5:0]  width,
  output logic        cmd_push,
  output rlbh_cmd_t   cmd,
  output front_stat_t stat
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] hdr_acc_r, hdr_acc_nxt;
  logic [2:0]  vbytes_r, vbytes_nxt;
  logic [31:0] val_acc_r, val_acc_nxt;
  logic [5:0]  bidx_r, bidx_nxt;
  logic [30:0] groups_r, groups_nxt;
  logic        failed_r, failed_nxt;
  logic [7:0]  grp_bytes_r [MAX_WIDTH];
  logic        grp_we;
  logic        trunc_err;

  logic [7:0]          b;
  logic                w_bad;
  logic [4:0]          hdr_sh;
  logic [31:0]         hdr_full;
  logic [2:0]          vb_inc;
  logic                hdr_ovf;
  logic [30:0]         run_cnt;
  logic [31:0]         val_new;
  logic [5:0]          bidx_inc;
  logic [6:0]          val_need;
  logic                val_done;
  logic                grp_done;
  logic [7:0]          cur_bytes [MAX_WIDTH];
  logic [GRP_BITS-1:0] snap;

  assign b        = item.in_byte;
  assign w_bad    = width > 6'(MAX_WIDTH);
  assign hdr_sh   = 5'({2'b00, vbytes_r} * 5'd7);
  assign hdr_full = hdr_acc_r | (32'(b & VARINT_PAYLOAD) << hdr_sh);
  assign vb_inc   = vbytes_r + 3'd1;
  assign hdr_ovf  = vb_inc >= VARINT_MAX_BYTES;
  assign run_cnt  = hdr_full[31:1];
  assign val_new  = val_acc_r | (32'(b) << {bidx_r[1:0], 3'b000});
  assign bidx_inc = bidx_r + 6'd1;
  assign val_need = ({1'b0, width} + 7'd7) >> 3;
  assign val_done = {1'b0, bidx_inc} >= val_need;
  assign grp_done = bidx_inc >= width;

  // Current group with this byte merged in.
  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      cur_bytes[j] = (6'(j) == bidx_r) ? b : grp_bytes_r[j];
    end
  end

  always_comb begin
    snap = '0;
    for (int j = 0; j < MAX_WIDTH; j++) begin
      snap[j*8 +: 8] = cur_bytes[j];
    end
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    hdr_acc_nxt = hdr_acc_r;
    vbytes_nxt  = vbytes_r;
    val_acc_nxt = val_acc_r;
    bidx_nxt    = bidx_r;
    groups_nxt  = groups_r;
    failed_nxt  = failed_r;
    grp_we      = 1'b0;
    trunc_err   = 1'b0;
    if (push) begin
      if (failed_r) begin
        // silent until end of data
      end else if (w_bad) begin
        failed_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (b[VARINT_CONT_BIT]) begin
              if (hdr_ovf) begin
                vbytes_nxt  = '0;
                hdr_acc_nxt = '0;
                failed_nxt  = 1'b1;
              end else begin
                hdr_acc_nxt = hdr_full;
                vbytes_nxt  = vb_inc;
              end
            end else begin
              hdr_acc_nxt = '0;
              vbytes_nxt  = '0;
              if (run_cnt != '0) begin
                bidx_nxt    = '0;
                val_acc_nxt = '0;
                if (width != '0) begin
                  groups_nxt = run_cnt;
                  phase_nxt  = hdr_full[0] ? PH_GROUP : PH_VALUE;
                end
              end
            end
          end
          PH_VALUE: begin
            val_acc_nxt = val_new;
            bidx_nxt    = bidx_inc;
            if (val_done) begin
              val_acc_nxt = '0;
              bidx_nxt    = '0;
              phase_nxt   = PH_HEADER;
            end
          end
          PH_GROUP: begin
            grp_we   = 1'b1;
            bidx_nxt = bidx_inc;
            if (grp_done) begin
              bidx_nxt   = '0;
              groups_nxt = groups_r - 31'd1;
              if (groups_r == 31'd1) begin
                phase_nxt = PH_HEADER;
              end
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
      if (item.end_of_data) begin
        trunc_err   = !failed_nxt && (phase_nxt != PH_HEADER || vbytes_nxt != '0);
        phase_nxt   = PH_HEADER;
        hdr_acc_nxt = '0;
        vbytes_nxt  = '0;
        val_acc_nxt = '0;
        bidx_nxt    = '0;
        groups_nxt  = '0;
        failed_nxt  = 1'b0;
      end
    end
  end

  // Command out
  always_comb begin
    cmd.kind     = CK_ERROR;
    cmd.tail_err = 1'b0;
    cmd.width    = width;
    cmd.value    = '0;
    cmd.count    = '0;
    cmd.grp      = snap;
    cmd_push     = 1'b0;
    if (push && !failed_r) begin
      if (w_bad) begin
        cmd_push = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (b[VARINT_CONT_BIT]) begin
              cmd_push = hdr_ovf;
            end else if (run_cnt != '0 && width == '0) begin
              cmd_push  = 1'b1;
              cmd.kind  = CK_SINGLE;
              cmd.count = hdr_full[0] ? {run_cnt, 3'b000} : 34'(run_cnt);
            end
          end
          PH_VALUE: begin
            if (val_done) begin
              cmd_push  = 1'b1;
              cmd.kind  = CK_SINGLE;
              cmd.value = val_new & width_mask(width);
              cmd.count = 34'(groups_r);
            end
          end
          PH_GROUP: begin
            if (grp_done) begin
              cmd_push = 1'b1;
              cmd.kind = CK_GROUP;
            end
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end
    end
    if (trunc_err) begin
      if (cmd_push) begin
        cmd.tail_err = 1'b1;
      end else begin
        cmd_push = 1'b1;
        cmd.kind = CK_ERROR;
      end
    end
  end

  assign stat.idle   = phase_r == PH_HEADER && vbytes_r == '0 && !failed_r;
  assign stat.failed = failed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_acc_r <= '0;
      vbytes_r  <= '0;
      val_acc_r <= '0;
      bidx_r    <= '0;
      groups_r  <= '0;
      failed_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_acc_r <= hdr_acc_nxt;
      vbytes_r  <= vbytes_nxt;
      val_acc_r <= val_acc_nxt;
      bidx_r    <= bidx_nxt;
      groups_r  <= groups_nxt;
      failed_r  <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      if (grp_we && 6'(j) == bidx_r) begin
        grp_bytes_r[j] <= b;
      end
    end
  end

endmodule

// ----- hw/rtl/rlbh_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// rlbh_cmd_queue
// Small command FIFO between the parser front and the result back.
// ----------------------------------------------------------------------------
module rlbh_cmd_queue
  import rlbh_pkg::*;
#(
  parameter int DEPTH = RLBH_CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rlbh_cmd_t wr_cmd,
  output logic      full,
  input  logic      pop,
  output rlbh_cmd_t rd_cmd,
  output logic      avail
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  rlbh_cmd_t       mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full   = cnt_r == CNTW'(DEPTH);
  assign avail  = cnt_r != '0;
  assign rd_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNTW'(1);
      2'b01:   cnt_nxt = cnt_r - CNTW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ----- hw/rtl/rlbh_back.sv -----
// ----------------------------------------------------------------------------
// rlbh_back
// Expands commands into result items, one per cycle while the result side pops, into an output register.
// ----------------------------------------------------------------------------
module rlbh_back
  import rlbh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rlbh_cmd_t cmd,
  input  logic      cmd_avail,
  output logic      cmd_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  logic [2:0] sub_r, sub_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  res;
  logic       emit;
  logic [2:0] last_idx;
  logic [8:0] grp_sh;
  logic [GRP_BITS-1:0] grp_shifted;

  assign emit        = cmd_avail && (!out_valid_r || out_pop);
  assign grp_sh      = 9'({6'b0, sub_r} * {3'b0, cmd.width});
  assign grp_shifted = cmd.grp >> grp_sh;

  always_comb begin
    res.value   = '0;
    res.run_len = '0;
    res.error   = 1'b1;
    last_idx    = '0;
    unique case (cmd.kind)
      CK_SINGLE: begin
        last_idx = cmd.tail_err ? 3'd1 : 3'd0;
        if (sub_r == '0) begin
          res.value   = cmd.value;
          res.run_len = cmd.count;
          res.error   = 1'b0;
        end
      end
      CK_GROUP: begin
        last_idx    = 3'd7;
        res.value   = grp_shifted[31:0] & width_mask(cmd.width);
        res.run_len = 34'd1;
        res.error   = cmd.tail_err && sub_r == 3'd7;
      end
      default: begin
        last_idx = '0;
      end
    endcase
    res.last = sub_r == last_idx;
  end

  assign cmd_pop = emit && res.last;

  always_comb begin
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      sub_nxt       = res.last ? '0 : sub_r + 3'd1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= res;
    end
  end

  assign out_item  = out_item_r;
  assign out_empty = !out_valid_r;

endmodule

// ----- hw/rtl/rle_bitpack_hybrid_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_bitpack_hybrid_decoder
// Decodes an RLE / bit-packing hybrid byte stream into (value, count) results.
// ----------------------------------------------------------------------------
//
//   channel   ports                          transfer when
//   -------   ----------------------------   ---------------------
//   input     in_item, in_push, in_full      in_push && !in_full
//   result    out_item, out_empty, out_pop   out_pop && !out_empty
//   config    cfg_we, cfg_wdata              cfg_we
//
// One byte is accepted per cycle while the command queue has room; a stalled
// result side fills the queue and then raises in_full. A byte gives at most
// eight results (a packed group), which leave the back one per cycle while the
// result side pops, through its output register. The first result of a byte
// passes the command queue and then that output register. Reset is synchronous,
// active low; the group byte store is not cleared.
// ----------------------------------------------------------------------------
module rle_bitpack_hybrid_decoder
  import rlbh_pkg::*;
#(
  parameter int MAX_WIDTH = RLBH_MAX_WIDTH,
  parameter int CMD_DEPTH = RLBH_CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       in_push,
  output logic       in_full,
  output out_item_t  out_item,
  output logic       out_empty,
  input  logic       out_pop,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic [5:0]  width_r, width_nxt;
  logic        in_acc;
  logic        cmd_push;
  rlbh_cmd_t   cmd_wr;
  rlbh_cmd_t   cmd_rd;
  logic        cmd_avail;
  logic        cmd_pop;
  front_stat_t front_stat;

  // Hold the value width; the user must write it only while the block is idle, which the block does not enforce.
  assign width_nxt = cfg_we ? cfg_wdata : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 6'd1;
    end else begin
      width_r <= width_nxt;
    end
  end

  assign in_acc = in_push && !in_full;

  // Front: parse every accepted byte, push a command when it yields results.
  rlbh_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_acc),
    .item    (in_item),
    .width   (width_r),
    .cmd_push(cmd_push),
    .cmd     (cmd_wr),
    .stat    (front_stat)
  );

  // Queue: lets the front keep taking bytes while the back drains a group.
  rlbh_cmd_queue #(
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wr_cmd(cmd_wr),
    .full  (in_full),
    .pop   (cmd_pop),
    .rd_cmd(cmd_rd),
    .avail (cmd_avail)
  );

  // Back: expand each command into results, advance one result per cycle while the result side pops.
  rlbh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_rd),
    .cmd_avail(cmd_avail),
    .cmd_pop  (cmd_pop),
    .out_item (out_item),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  // End of data always returns the parser to idle with the failure cleared.
  a_eod_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.end_of_data |=> front_stat.idle && !front_stat.failed)
    else $error("parser not idle after end of data");

  // A zero count only comes from an error result, which ends its byte.
  a_zero_count_err: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.run_len == '0
      |-> out_item.error && out_item.value == '0 && out_item.last)
    else $error("zero-count result that is not an error");

  // After a failure only the end-of-data byte may produce a command.
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.failed && in_acc && !in_item.end_of_data |-> !cmd_push)
    else $error("command pushed while failed");

endmodule

// ----- verif/rlbh_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbh_result_checker
// Watches the byte, result and width channels of the hybrid decoder, decodes
// every accepted byte on its own and compares each popped result with the
// oldest decoded one.
// ----------------------------------------------------------------------------
module rlbh_result_checker
  import rlbh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       in_push,
  input  logic       in_full,
  input  out_item_t  out_item,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  output int         fail_count,
  output int         pending,
  output int         result_count,
  output int         error_count
);

  localparam int WIDTH_LIMIT = RLBH_MAX_WIDTH;

  // decoder state as this side sees it
  logic [5:0]  width;
  phase_t      stage;
  logic [31:0] hdr_acc;
  int unsigned hdr_len;
  logic [31:0] val_acc;
  int unsigned byte_idx;
  logic [31:0] run_left;
  logic [7:0]  grp_bytes [32];
  logic        halted;

  out_item_t   decoded_q [$];
  int          mismatches;
  int          checked;
  int          flagged;

  function automatic out_item_t make_item(input logic [31:0] v, input logic [33:0] n,
                                          input logic e);
    out_item_t it;
    it.value   = v;
    it.run_len = n;
    it.error   = e;
    it.last    = 1'b0;
    return it;
  endfunction

  task automatic clear_run();
    stage    = PH_HEADER;
    hdr_acc  = '0;
    hdr_len  = 0;
    val_acc  = '0;
    byte_idx = 0;
    run_left = '0;
    halted   = 1'b0;
    foreach (grp_bytes[i]) grp_bytes[i] = '0;
  endtask

  // Decode one byte and queue the results it causes.
  task automatic decode_byte(input logic [7:0] b, input logic eod);
    out_item_t   batch [$];
    out_item_t   tail;
    logic [31:0] hdr;
    logic [31:0] cnt;
    logic [31:0] val;
    logic [31:0] mask;
    int unsigned bit_pos;
    if (halted) begin
      // silent until end of data
    end else if (width > WIDTH_LIMIT) begin
      batch.push_back(make_item('0, '0, 1'b1));
      halted = 1'b1;
    end else if (stage == PH_HEADER) begin
      hdr_acc = hdr_acc | (32'(b[6:0]) << ((7 * hdr_len) % 32));
      hdr_len++;
      if (b[7]) begin
        if (hdr_len >= 5) begin
          hdr_acc = '0;
          hdr_len = 0;
          batch.push_back(make_item('0, '0, 1'b1));
          halted = 1'b1;
        end
      end else begin
        hdr     = hdr_acc;
        hdr_acc = '0;
        hdr_len = 0;
        cnt     = hdr >> 1;
        if (cnt != 0) begin
          byte_idx = 0;
          val_acc  = '0;
          if (width == 0) begin
            batch.push_back(make_item('0, hdr[0] ? (34'(cnt) << 3) : 34'(cnt), 1'b0));
          end else begin
            run_left = cnt;
            stage    = hdr[0] ? PH_GROUP : PH_VALUE;
          end
        end
      end
    end else if (stage == PH_VALUE) begin
      val_acc = val_acc | (32'(b) << (8 * (byte_idx % 4)));
      byte_idx++;
      if (byte_idx >= (int'(width) + 7) / 8) begin
        mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
        batch.push_back(make_item(val_acc & mask, 34'(run_left), 1'b0));
        val_acc  = '0;
        byte_idx = 0;
        stage    = PH_HEADER;
      end
    end else begin
      grp_bytes[byte_idx % 32] = b;
      byte_idx++;
      if (byte_idx >= width) begin
        // unpack eight values LSB-first
        for (int i = 0; i < 8; i++) begin
          val = '0;
          for (int k = 0; k < int'(width); k++) begin
            bit_pos = i * width + k;
            val[k]  = grp_bytes[(bit_pos >> 3) % 32][bit_pos % 8];
          end
          batch.push_back(make_item(val, 34'd1, 1'b0));
        end
        byte_idx = 0;
        run_left = run_left - 1;
        if (run_left == 0) stage = PH_HEADER;
      end
    end

    if (eod) begin
      // a run cut short flags an error; a full burst flags its eighth value
      if (!halted && (stage != PH_HEADER || hdr_len != 0)) begin
        if (batch.size() >= 8) begin
          tail = batch.pop_back();
          tail.error = 1'b1;
          batch.push_back(tail);
        end else begin
          batch.push_back(make_item('0, '0, 1'b1));
        end
      end
      clear_run();
    end

    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[i]) decoded_q.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      width = 6'd1;
      clear_run();
      decoded_q.delete();
    end else begin
      if (cfg_we) width = cfg_wdata;
      if (in_push && !in_full) decode_byte(in_item.in_byte, in_item.end_of_data);
      if (out_pop && !out_empty) begin
        checked++;
        if (out_item.error) flagged++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 40) begin
            $display("%0t: unexpected result: value=%h count=%h error=%b last=%b", $time,
                     out_item.value, out_item.run_len, out_item.error, out_item.last);
          end
        end else begin
          exp_item = decoded_q.pop_front();
          if (out_item.value !== exp_item.value ||
              out_item.run_len !== exp_item.run_len ||
              out_item.error !== exp_item.error || out_item.last !== exp_item.last) begin
            mismatches++;
            if (mismatches <= 40) begin
              $display("%0t: result %0d: expected value=%h count=%h error=%b last=%b", $time,
                       checked, exp_item.value, exp_item.run_len, exp_item.error,
                       exp_item.last);
              $display("%0t: result %0d: actual   value=%h count=%h error=%b last=%b", $time,
                       checked, out_item.value, out_item.run_len, out_item.error,
                       out_item.last);
            end
          end
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= decoded_q.size();
    result_count <= checked;
    error_count  <= flagged;
  end

endmodule

// ----- verif/tb_rle_bitpack_hybrid_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_bitpack_hybrid_decoder
// Feeds the hybrid decoder encoded byte streams: a directed opening on the
// corner cases, then randomly built streams of repeat and packed runs with
// noise and truncation, at value widths 0 to 63 and under varying idling on
// both channels. A separate checker decodes and compares every result.
// ----------------------------------------------------------------------------
module tb_rle_bitpack_hybrid_decoder;
  import rlbh_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  // the first result of a byte passes the command queue and the output register
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 100;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  in_item_t   in_item   = '0;
  logic       in_push   = 1'b0;
  logic       in_full;
  out_item_t  out_item;
  logic       out_empty;
  logic       out_pop   = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [5:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int result_count;
  int error_count;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent     = 0;
  int          streams        = 0;
  int          cycles         = 0;
  logic [5:0]  cur_width      = 6'd1;
  logic [7:0]  stream_q [$];

  rle_bitpack_hybrid_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_push   (in_push),
    .in_full   (in_full),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rlbh_result_checker results_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .in_push      (in_push),
    .in_full      (in_full),
    .out_item     (out_item),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .error_count  (error_count)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycles, pending);
      $display("tb_rle_bitpack_hybrid_decoder: errors");
      $finish;
    end
  end

  // Result side: pop at random, stalling recv_stall_pct of the cycles.
  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  // in_push stays high afterwards so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_item.in_byte     <= b;
    in_item.end_of_data <= eod;
    in_push             <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop push and hold off until every decoded result has been popped, then
  // let the decoder settle in case the last bytes gave no result.
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Width writes only happen with nothing in flight.
  task automatic set_width(input logic [5:0] w);
    wait_drained();
    cfg_wdata <= w;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_width = w;
  endtask

  // LEB128 header; now and then a redundant zero byte keeps it non-minimal.
  function automatic void put_varint(input logic [31:0] h);
    logic [31:0] rest;
    int          n;
    rest = h;
    n    = 0;
    while (rest > 32'd127) begin
      stream_q.push_back({1'b1, rest[6:0]});
      rest = rest >> 7;
      n++;
    end
    if (n < 4 && $urandom_range(7) == 0) begin
      stream_q.push_back({1'b1, rest[6:0]});
      rest = '0;
    end
    stream_q.push_back({1'b0, rest[6:0]});
  endfunction

  // One run with random content at width w, well-formed unless a huge group count cuts it short.
  function automatic void put_run(input logic [5:0] w);
    logic        kind;
    logic [30:0] cnt;
    int          sel;
    int          groups;
    kind = 1'($urandom_range(1));
    sel  = $urandom_range(99);
    if (sel < 8) begin
      cnt = '0;
    end else if (sel < 80) begin
      cnt = 31'($urandom_range(kind ? 3 : 20, 1));
    end else begin
      cnt = 31'($urandom_range(32'h7FFF_FFFF, 1));
    end
    put_varint({cnt, kind});
    if (cnt != 0 && w != 0) begin
      if (!kind) begin
        repeat ((int'(w) + 7) / 8) stream_q.push_back(8'($urandom));
      end else begin
        // huge group counts send up to two groups and end truncated
        groups = (cnt <= 3) ? int'(cnt) : $urandom_range(2, 0);
        repeat (groups * int'(w)) stream_q.push_back(8'($urandom));
      end
    end
  endfunction

  // A stream is a handful of runs, noise or a cut-off run, ended by end_of_data.
  function automatic void build_stream(input logic [5:0] w);
    int n_runs;
    int sel;
    int start;
    int cut;
    stream_q.delete();
    n_runs = $urandom_range(5, 1);
    for (int r = 0; r < n_runs; r++) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        repeat ($urandom_range(4, 1)) stream_q.push_back(8'($urandom));
      end else begin
        start = stream_q.size();
        put_run(w);
        if (sel >= 85 && stream_q.size() - start >= 2) begin
          cut = $urandom_range(stream_q.size() - 1, start + 1);
          while (stream_q.size() > cut) void'(stream_q.pop_back());
          break;
        end
      end
    end
  endfunction

  function automatic logic [5:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 6'd0;
    if (r < 20) return 6'd32;
    if (r < 25) return 6'($urandom_range(63, 33));
    if (r < 70) return 6'($urandom_range(8, 1));
    return 6'($urandom_range(31, 9));
  endfunction

  int send_plan [4] = '{0, 68, 0, 28};
  int recv_plan [4] = '{0, 0, 68, 28};

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed opening ----
    // width 1 from reset: a repeat run and a one-group packed run
    send_byte(8'h0A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hA5, 1'b0);
    // empty runs of both kinds, stream closed at a run boundary
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    // zero width: both run kinds answer straight from the header
    set_width(6'd0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h05, 1'b1);
    // full width behind a five-byte header whose top bits fall off
    set_width(6'd32);
    repeat (4) send_byte(8'h80, 1'b0);
    send_byte(8'h7E, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // over-long header, then silence up to end of data
    repeat (5) send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    // value cut short by end of data
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b1);
    streams += 4;
    // group completed on the final byte of a longer packed run
    set_width(6'd8);
    send_byte(8'h05, 1'b0);
    repeat (7) send_byte(8'($urandom), 1'b0);
    send_byte(8'hC3, 1'b1);
    // header cut short
    send_byte(8'h81, 1'b1);
    // width beyond the supported range
    set_width(6'd63);
    send_byte(8'h00, 1'b1);
    // width shrinks in the middle of a group
    set_width(6'd16);
    send_byte(8'h03, 1'b0);
    send_byte(8'h12, 1'b0);
    set_width(6'd1);
    send_byte(8'h34, 1'b1);
    streams += 4;
    wait_drained();

    // ---- random streams, one idling profile per phase ----
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if ($urandom_range(1) == 1) set_width(pick_width());
        build_stream(cur_width);
        foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
        streams++;
      end
      wait_drained();
    end

    $display("run: %0d bytes in %0d streams, widths 0 to 63, four idling profiles",
             bytes_sent, streams);
    $display("run: %0d results checked, %0d flagged as stream errors", result_count,
             error_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rle_bitpack_hybrid_decoder: clean");
    end else begin
      $display("tb_rle_bitpack_hybrid_decoder: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rlbh_pkg.sv
hw/rtl/rlbh_front.sv
hw/rtl/rlbh_cmd_queue.sv
hw/rtl/rlbh_back.sv
hw/rtl/rle_bitpack_hybrid_decoder.sv
verif/rlbh_result_checker.sv
verif/tb_rle_bitpack_hybrid_decoder.sv
